### src/xte_pkg.sv
package xte_pkg;

    // Longest entity name that is held before the entity is broken.
    localparam int NAME_MAX = 10;

    // Held-name count, held-array index and sequencing index widths.
    localparam int CNT_W  = $clog2(NAME_MAX + 1);
    localparam int HIDX_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
    localparam int IDX_W  = (CNT_W > 3) ? CNT_W : 3;
    localparam int IDXP_W = IDX_W + 1;

    // Character codes.
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;

    // Position of the last character in the escape strings.
    localparam logic [2:0] AMP_STR_LAST   = 3'd4;
    localparam logic [2:0] ANGLE_STR_LAST = 3'd3;

    // Byte classes that steer the controller.
    typedef struct packed {
        logic is_amp;
        logic is_semi;
        logic is_lt;
        logic is_gt;
        logic is_name;
    } cls_t;

    // Source of the next output byte.
    typedef enum logic [2:0] {
        SEL_AMP_STR,
        SEL_ANGLE_STR,
        SEL_HELD,
        SEL_BYTE,
        SEL_CHAR_AMP,
        SEL_CHAR_SEMI
    } sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic hold;
        logic cnt_clr;
        logic emit;
        sel_t sel;
        logic last;
        logic idx_inc;
        logic idx_clr;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cls_t in_cls;
        cls_t lat_cls;
        logic lat_end;
        logic cnt_zero;
        logic cnt_full;
        logic idx_amp_end;
        logic idx_angle_end;
        logic idx_held_end;
        logic out_free;
    } status_t;

    // Classify one text byte.
    function automatic cls_t classify(input logic [7:0] b);
        cls_t c;
        c.is_amp  = (b == CH_AMP);
        c.is_semi = (b == CH_SEMI);
        c.is_lt   = (b == CH_LT);
        c.is_gt   = (b == CH_GT);
        c.is_name = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
                    ((b >= 8'h30) && (b <= 8'h39)) || (b == CH_HASH) || (b == CH_DASH);
        return c;
    endfunction

    // Characters of "&amp;".
    function automatic logic [7:0] amp_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = CH_AMP;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h6D;
            3'd3:    ch = 8'h70;
            default: ch = CH_SEMI;
        endcase
        return ch;
    endfunction

    // Characters of "&lt;" or "&gt;".
    function automatic logic [7:0] angle_char(input logic gt, input logic [1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0:    ch = CH_AMP;
            2'd1:    ch = gt ? 8'h67 : 8'h6C;
            2'd2:    ch = 8'h74;
            default: ch = CH_SEMI;
        endcase
        return ch;
    endfunction

endpackage

### src/xml_text_escaper.sv
// XML text escaper.
// The input stream carries one text byte per request (s_tdata) with s_tlast
// set on the final byte of a text node. The output stream carries one escaped
// byte per request (m_tdata); m_tlast marks the last byte caused by an input
// request and m_tuser the final byte of the whole text.
// '<' and '>' become "&lt;" and "&gt;". After '&', up to ten name bytes are
// held; a ';' after a non-empty name passes the reference through, while
// anything else emits "&amp;" and the held bytes, then handles the breaking
// byte afresh. Held bytes give no output yet.
// One output byte per cycle, while the receiver takes it, passes through
// the single output register; input is taken only while the controller is
// idle, so a new request waits until the controller is done with the last.
// Reset clears the controller and any pending entity; the output goes idle.
// When the receiver stalls, the output register holds its byte and the
// controller waits, so input requests stall in turn.
module xml_text_escaper (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // text_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // text_done
);

    xte_pkg::cmd_t    cmd;
    xte_pkg::status_t status;

    xte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    xte_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // The last byte of a text is always the last byte of its request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("text_done without run_last");

    // A name byte is never stored into a full name buffer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.hold |-> !status.cnt_full)
        else $error("held name overflow");

    // The controller only emits when the output register can take a byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("emit into an occupied output register");

    // A taken output byte is not shown again unless a new one was loaded.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !cmd.emit |=> !m_tvalid)
        else $error("output byte repeated");
`endif

endmodule

### src/xte_datapath.sv
module xte_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_tdata,   // [7:0] in_byte
    input  logic               s_tlast,   // text_end
    input  xte_pkg::cmd_t      cmd,
    output xte_pkg::status_t   status,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [7:0] out_byte
    output logic               m_tlast,   // run_last
    output logic               m_tuser    // text_done
);

    logic [7:0]                 byte_reg;
    logic                       end_reg;
    logic [7:0]                 held_reg [xte_pkg::NAME_MAX];
    logic [xte_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [xte_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [7:0]                 out_byte_reg, out_byte_next;
    logic                       out_last_reg;
    logic                       out_done_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_free;
    xte_pkg::cls_t              lat_cls;

    assign lat_cls  = xte_pkg::classify(byte_reg);
    assign out_free = !out_valid_reg || m_tready;

    // Status toward the controller.
    always_comb begin
        status.in_cls        = xte_pkg::classify(s_tdata);
        status.lat_cls       = lat_cls;
        status.lat_end       = end_reg;
        status.cnt_zero      = (cnt_reg == '0);
        status.cnt_full      = (cnt_reg == xte_pkg::CNT_W'(xte_pkg::NAME_MAX));
        status.idx_amp_end   = (idx_reg[2:0] == xte_pkg::AMP_STR_LAST);
        status.idx_angle_end = (idx_reg[2:0] == xte_pkg::ANGLE_STR_LAST);
        status.idx_held_end  = ((xte_pkg::IDXP_W'(idx_reg) + xte_pkg::IDXP_W'(1))
                                == xte_pkg::IDXP_W'(cnt_reg));
        status.out_free      = out_free;
    end

    // Held-name count and sequencing index.
    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr) begin
            cnt_next = '0;
        end else if (cmd.hold) begin
            cnt_next = cnt_reg + xte_pkg::CNT_W'(1);
        end
        idx_next = idx_reg;
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + xte_pkg::IDX_W'(1);
        end
    end

    // Output byte selection.
    always_comb begin
        unique case (cmd.sel)
            xte_pkg::SEL_AMP_STR:   out_byte_next = xte_pkg::amp_char(idx_reg[2:0]);
            xte_pkg::SEL_ANGLE_STR: out_byte_next =
                                        xte_pkg::angle_char(lat_cls.is_gt, idx_reg[1:0]);
            xte_pkg::SEL_HELD:      out_byte_next = held_reg[idx_reg[xte_pkg::HIDX_W-1:0]];
            xte_pkg::SEL_BYTE:      out_byte_next = byte_reg;
            xte_pkg::SEL_CHAR_AMP:  out_byte_next = xte_pkg::CH_AMP;
            xte_pkg::SEL_CHAR_SEMI: out_byte_next = xte_pkg::CH_SEMI;
            default:                out_byte_next = byte_reg;
        endcase
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: input latch, held name bytes and output register.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= s_tdata;
            end_reg  <= s_tlast;
        end
        if (cmd.hold) begin
            held_reg[cnt_reg[xte_pkg::HIDX_W-1:0]] <= s_tdata;
        end
        if (cmd.emit) begin
            out_byte_reg <= out_byte_next;
            out_last_reg <= cmd.last;
            out_done_reg <= cmd.last && end_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

### src/xte_ctrl.sv
module xte_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tlast,
    output logic               s_tready,
    input  xte_pkg::status_t   status,
    output xte_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FLUSH_AMP,
        ST_FLUSH_HELD,
        ST_FRESH,
        ST_REF_OPEN,
        ST_REF_HELD,
        ST_REF_CLOSE,
        ST_STR,
        ST_BYTE
    } state_t;

    state_t         state_reg, state_next;
    logic           pending_reg, pending_next;
    logic           then_fresh_reg, then_fresh_next;
    logic           more_reg, more_next;
    logic           do_fresh;
    logic           flush_done;
    xte_pkg::cls_t  f_cls;
    logic           f_end;

    assign s_tready = (state_reg == ST_IDLE);

    // A fresh byte is the incoming one when idle, else the latched one.
    assign f_cls = (state_reg == ST_IDLE) ? status.in_cls : status.lat_cls;
    assign f_end = (state_reg == ST_IDLE) ? s_tlast : status.lat_end;

    always_comb begin
        state_next      = state_reg;
        pending_next    = pending_reg;
        then_fresh_next = then_fresh_reg;
        more_next       = more_reg;
        do_fresh        = 1'b0;
        flush_done      = 1'b0;
        cmd             = '0;
        cmd.sel         = xte_pkg::SEL_BYTE;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (pending_reg) begin
                        priority if (status.in_cls.is_semi && !status.cnt_zero) begin
                            state_next = ST_REF_OPEN;
                        end else if (status.in_cls.is_name && !status.cnt_full) begin
                            cmd.hold = 1'b1;
                            if (s_tlast) begin
                                state_next      = ST_FLUSH_AMP;
                                then_fresh_next = 1'b0;
                                more_next       = 1'b0;
                            end
                        end else begin
                            // The byte breaks the entity and is handled afresh.
                            state_next      = ST_FLUSH_AMP;
                            then_fresh_next = 1'b1;
                            more_next       = !(status.in_cls.is_amp && !s_tlast);
                        end
                    end else begin
                        do_fresh = 1'b1;
                    end
                end
            end
            ST_FLUSH_AMP: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = xte_pkg::SEL_AMP_STR;
                    if (status.idx_amp_end) begin
                        cmd.idx_clr = 1'b1;
                        if (status.cnt_zero) begin
                            cmd.last   = !more_reg;
                            flush_done = 1'b1;
                        end else begin
                            state_next = ST_FLUSH_HELD;
                        end
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_FLUSH_HELD: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = xte_pkg::SEL_HELD;
                    if (status.idx_held_end) begin
                        cmd.idx_clr = 1'b1;
                        cmd.last    = !more_reg;
                        flush_done  = 1'b1;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_FRESH: begin
                do_fresh = 1'b1;
            end
            ST_REF_OPEN: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = xte_pkg::SEL_CHAR_AMP;
                    state_next = ST_REF_HELD;
                end
            end
            ST_REF_HELD: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = xte_pkg::SEL_HELD;
                    if (status.idx_held_end) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_REF_CLOSE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_REF_CLOSE: begin
                if (status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.sel      = xte_pkg::SEL_CHAR_SEMI;
                    cmd.last     = 1'b1;
                    pending_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            ST_STR: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = xte_pkg::SEL_ANGLE_STR;
                    if (status.idx_angle_end) begin
                        cmd.idx_clr = 1'b1;
                        cmd.last    = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_BYTE: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = xte_pkg::SEL_BYTE;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A finished flush closes the entity.
        if (flush_done) begin
            pending_next = 1'b0;
            state_next   = then_fresh_reg ? ST_FRESH : ST_IDLE;
        end

        // Fresh handling of a byte outside an entity.
        if (do_fresh) begin
            priority if (f_cls.is_amp) begin
                pending_next = 1'b1;
                cmd.cnt_clr  = 1'b1;
                if (f_end) begin
                    state_next      = ST_FLUSH_AMP;
                    then_fresh_next = 1'b0;
                    more_next       = 1'b0;
                end else begin
                    state_next = ST_IDLE;
                end
            end else if (f_cls.is_lt || f_cls.is_gt) begin
                state_next = ST_STR;
            end else begin
                state_next = ST_BYTE;
            end
        end
    end

    // State and control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pending_reg    <= 1'b0;
            then_fresh_reg <= 1'b0;
            more_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pending_reg    <= pending_next;
            then_fresh_reg <= then_fresh_next;
            more_reg       <= more_next;
        end
    end

endmodule

### bench/escape_checker.sv
module escape_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // text_end
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    input  logic       m_tlast,   // run_last
    input  logic       m_tuser,   // text_done
    output int         fail_count,
    output int         results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_done;
    } escaped_byte_t;

    // Escaped bytes still owed by the block, oldest first.
    escaped_byte_t escaped_q[$];
    // Bytes produced by the request that is being predicted.
    logic [7:0]    run_bytes[$];

    // Shadow of the pending entity.
    logic          entity_open;
    int unsigned   held_len;
    logic [7:0]    name_buf[xte_pkg::NAME_MAX];
    int            fails = 0;

    // Letters, digits, '#' and '-' may appear in an entity name.
    function automatic logic is_name_char(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h30 && b <= 8'h39) || b == xte_pkg::CH_HASH ||
               b == xte_pkg::CH_DASH;
    endfunction

    task automatic emit_string(input string s);
        for (int i = 0; i < s.len(); i++)
            run_bytes.push_back(s[i]);
    endtask

    task automatic emit_name();
        for (int k = 0; k < held_len; k++)
            run_bytes.push_back(name_buf[k]);
    endtask

    // A broken entity comes out as an escaped ampersand and the raw name.
    task automatic break_entity();
        emit_string("&amp;");
        emit_name();
        entity_open = 1'b0;
        held_len    = 0;
    endtask

    task automatic escape_text_byte(input logic [7:0] b);
        if (entity_open) begin
            // A semicolon after a non-empty name closes a reference as it stands.
            if (b == xte_pkg::CH_SEMI && held_len > 0) begin
                run_bytes.push_back(xte_pkg::CH_AMP);
                emit_name();
                run_bytes.push_back(xte_pkg::CH_SEMI);
                entity_open = 1'b0;
                held_len    = 0;
                return;
            end
            if (is_name_char(b) && held_len < xte_pkg::NAME_MAX) begin
                name_buf[held_len] = b;
                held_len++;
                return;
            end
            // Anything else breaks the entity and is then treated afresh.
            break_entity();
        end
        if (b == xte_pkg::CH_AMP) begin
            entity_open = 1'b1;
            held_len    = 0;
        end else if (b == xte_pkg::CH_LT) begin
            emit_string("&lt;");
        end else if (b == xte_pkg::CH_GT) begin
            emit_string("&gt;");
        end else begin
            run_bytes.push_back(b);
        end
    endtask

    task automatic predict_request(input logic [7:0] b, input logic text_end);
        escaped_byte_t e;
        run_bytes.delete();
        escape_text_byte(b);
        if (text_end && entity_open)
            break_entity();
        foreach (run_bytes[i]) begin
            e.out_byte  = run_bytes[i];
            e.run_last  = (i == run_bytes.size() - 1);
            e.text_done = e.run_last && text_end;
            escaped_q.push_back(e);
        end
    endtask

    // Predict on every input request, then check every output request.
    always @(posedge aclk) begin
        escaped_byte_t want;
        if (!aresetn) begin
            entity_open = 1'b0;
            held_len    = 0;
            escaped_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                predict_request(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (escaped_q.size() == 0) begin
                    $error("unexpected output request: out_byte %h", m_tdata);
                    fails++;
                end else begin
                    want = escaped_q.pop_front();
                    if (m_tdata !== want.out_byte) begin
                        $error("out_byte: expected %h, got %h", want.out_byte, m_tdata);
                        fails++;
                    end
                    if (m_tlast !== want.run_last) begin
                        $error("run_last: expected %b, got %b", want.run_last, m_tlast);
                        fails++;
                    end
                    if (m_tuser !== want.text_done) begin
                        $error("text_done: expected %b, got %b", want.text_done, m_tuser);
                        fails++;
                    end
                end
            end
        end
        fail_count   <= fails;
        results_owed <= escaped_q.size();
    end

endmodule

### bench/xml_text_escaper_test.sv
module xml_text_escaper_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_BYTES = 125;
    localparam int RUN_LIMIT    = 200000;
    localparam int TAIL_CYCLES  = 12;

    // Receiver behavior, picked anew at random whenever its spell runs out.
    typedef enum logic [1:0] {
        DRAIN_FREE,
        DRAIN_LIGHT,
        DRAIN_HEAVY,
        DRAIN_PULSE
    } drain_mode_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    int          fail_count;
    int          results_owed;
    int          cycle_count = 0;
    int          bytes_sent  = 0;
    int          burst_left  = 0;
    drain_mode_t drain_mode  = DRAIN_FREE;
    int          drain_left  = 0;

    xml_text_escaper dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    escape_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // Receiver stalls: free running, light or heavy random stalls, or a pulse train.
    always @(posedge aclk) begin
        if (drain_left == 0) begin
            drain_mode <= drain_mode_t'($urandom_range(0, 3));
            drain_left <= $urandom_range(16, 96);
        end else begin
            drain_left <= drain_left - 1;
        end
        case (drain_mode)
            DRAIN_FREE:  m_tready <= 1'b1;
            DRAIN_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
            DRAIN_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
            default:     m_tready <= drain_left[2];
        endcase
    end

    // Send one request and wait for it to be taken; bursts end in a random gap.
    task automatic send_text_byte(input logic [7:0] b, input logic text_end);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= text_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
        end
    endtask

    task automatic send_text(input string s, input logic end_on_last);
        for (int i = 0; i < s.len(); i++)
            send_text_byte(s[i], end_on_last && (i == s.len() - 1));
    endtask

    // Hold the input off until every owed byte has come out.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_name_char();
        int pick;
        pick = $urandom_range(0, 63);
        if (pick < 26)
            return 8'(pick + 8'h61);
        else if (pick < 52)
            return 8'(pick - 26 + 8'h41);
        else if (pick < 62)
            return 8'(pick - 52 + 8'h30);
        else if (pick == 62)
            return xte_pkg::CH_HASH;
        else
            return xte_pkg::CH_DASH;
    endfunction

    function automatic logic random_text_end();
        return ($urandom_range(0, 11) == 0);
    endfunction

    // One random run: a plain byte, a bracket, a reference, a broken or an
    // overlong entity. The text may end anywhere inside it.
    task automatic send_random_run();
        int         kind;
        int         name_chars;
        logic [7:0] breaker;
        kind = $urandom_range(0, 9);
        if (kind <= 2) begin
            send_text_byte(8'($urandom_range(0, 255)), random_text_end());
        end else if (kind <= 3) begin
            send_text_byte($urandom_range(0, 1) ? xte_pkg::CH_LT : xte_pkg::CH_GT,
                           random_text_end());
        end else begin
            send_text_byte(xte_pkg::CH_AMP, random_text_end());
            if (kind == 9)
                name_chars = xte_pkg::NAME_MAX + 1;
            else if (kind == 8)
                name_chars = $urandom_range(0, xte_pkg::NAME_MAX);
            else
                name_chars = $urandom_range(1, xte_pkg::NAME_MAX);
            for (int i = 0; i < name_chars; i++)
                send_text_byte(random_name_char(), random_text_end());
            if (kind <= 7) begin
                send_text_byte(xte_pkg::CH_SEMI, random_text_end());
            end else if (kind == 8) begin
                case ($urandom_range(0, 4))
                    0:       breaker = xte_pkg::CH_SEMI;
                    1:       breaker = xte_pkg::CH_AMP;
                    2:       breaker = xte_pkg::CH_LT;
                    3:       breaker = 8'($urandom_range(128, 255));
                    default: breaker = 8'($urandom_range(0, 255));
                endcase
                send_text_byte(breaker, random_text_end());
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Byte extremes, both brackets, a reference with '#', an empty name,
        // a breaking ampersand with the text ending while pending, and an
        // overlong name.
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        send_text("<>", 1'b0);
        send_text("&#x;", 1'b0);
        send_text("&;", 1'b0);
        send_text("&&Z", 1'b1);
        send_text("&aZ09-#bcdeq", 1'b1);
        wait_for_drain();

        while (bytes_sent < 25 + RANDOM_BYTES) begin
            send_random_run();
            if ($urandom_range(0, 39) == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Run limit.
    initial begin
        while (cycle_count < RUN_LIMIT) @(posedge aclk);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
